/* rtl/kdc_pkg.sv */
// Shared key codes, event codes and status types of the keypad decimal calculator.
package kdc_pkg;

    // Fixed width of the decimal entry and result fields on the result channel
    localparam int OUT_W = 32;

    // ASCII key codes
    localparam logic [7:0] KEY_0 = 8'h30;
    localparam logic [7:0] KEY_9 = 8'h39;
    localparam logic [7:0] KEY_A = 8'h41;
    localparam logic [7:0] KEY_B = 8'h42;
    localparam logic [7:0] KEY_C = 8'h43;
    localparam logic [7:0] KEY_D = 8'h44;
    localparam logic [7:0] KEY_E = 8'h45;
    localparam logic [7:0] KEY_F = 8'h46;

    // Event codes reported with every result item
    localparam logic [3:0] EV_IGNORED   = 4'd0;
    localparam logic [3:0] EV_DIGIT     = 4'd1;
    localparam logic [3:0] EV_OVF_RESET = 4'd2;
    localparam logic [3:0] EV_CLEARED   = 4'd3;
    localparam logic [3:0] EV_STORED    = 4'd4;
    localparam logic [3:0] EV_FULL      = 4'd5;
    localparam logic [3:0] EV_RESULT    = 4'd6;
    localparam logic [3:0] EV_OVERFLOW  = 4'd7;
    localparam logic [3:0] EV_PAL       = 4'd8;

    // Status returned by the palindrome unit
    typedef struct packed {
        logic done;
        logic is_pal;
    } pal_stat_t;

endpackage

/* rtl/keypad_decimal_calculator_unit.sv */
// Top level of the keypad decimal calculator: sequencer, operand store and result register.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata[7:0] key_code
//  m_      | out | m_tvalid/m_tready  | m_tuser[3:0] event_code, m_tdata entry/result/flags
//
//  D runs the binary to BCD conversion of the palindrome unit on each operand in turn.
//  The block takes one key at a time; s_tready is high only while the sequencer idles.
//  A finished result waits in the output register, so the next key can be taken meanwhile;
//  the sequencer stalls in its last step while that register is still full.
//  aresetn (synchronous, active low) clears the entry, the operand count and the handshakes.
module keypad_decimal_calculator_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // key_code [7:0]
    input  logic [7:0]  s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // entry_value [31:0], result_value [63:32], held_operands [65:64],
    // first_is_palindrome [66], second_is_palindrome [67], white_light [68], zero [71:69]
    output logic [71:0] m_tdata,
    // event_code [3:0]
    output logic [3:0]  m_tuser,
    output logic        m_tvalid,
    input  logic        m_tready
);

    localparam int W  = VALUE_WIDTH;
    localparam int AW = W + 4;              // room for ten times the entry plus a digit
    localparam int CW = $clog2(W + 1);
    localparam int OW = kdc_pkg::OUT_W;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_MUL10  = 4'd1;
    localparam logic [3:0] ST_ADDD   = 4'd2;
    localparam logic [3:0] ST_ADD    = 4'd3;
    localparam logic [3:0] ST_SUB    = 4'd4;
    localparam logic [3:0] ST_MUL    = 4'd5;
    localparam logic [3:0] ST_MULEND = 4'd6;
    localparam logic [3:0] ST_PALA   = 4'd7;
    localparam logic [3:0] ST_PALA_W = 4'd8;
    localparam logic [3:0] ST_PALB   = 4'd9;
    localparam logic [3:0] ST_PALB_W = 4'd10;
    localparam logic [3:0] ST_FINISH = 4'd11;

    // Sequencer and operand state
    logic [3:0]    state_reg, state_next;
    logic [W-1:0]  entry_reg, entry_next;
    logic [W-1:0]  opnd0_reg, opnd0_next;
    logic [W-1:0]  opnd1_reg, opnd1_next;
    logic [1:0]    count_reg, count_next;
    logic [3:0]    digit_reg, digit_next;
    logic [AW-1:0] acc_reg, acc_next;
    logic [W-1:0]  lo_reg, lo_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    // Pending result of the key being worked on
    logic [3:0]    ev_reg, ev_next;
    logic [W-1:0]  res_reg, res_next;
    logic          p1_reg, p1_next;
    logic          p2_reg, p2_next;

    // Output register
    logic          m_valid_reg, m_valid_next;
    logic [3:0]    m_ev_reg, m_ev_next;
    logic [OW-1:0] m_entry_reg, m_entry_next;
    logic [OW-1:0] m_res_reg, m_res_next;
    logic [1:0]    m_held_reg, m_held_next;
    logic          m_p1_reg, m_p1_next;
    logic          m_p2_reg, m_p2_next;
    logic          m_wl_reg, m_wl_next;

    // Shared adder
    logic [AW-1:0] alu_x, alu_y, alu_sum;
    logic          alu_sub;

    // Palindrome unit
    logic               pal_start;
    logic [W-1:0]       pal_value;
    kdc_pkg::pal_stat_t pal_stat;

    logic [OW+W-1:0] entry_wide;
    logic [OW+W-1:0] res_wide;

    kdc_alu #(
        .WIDTH (AW)
    ) u_alu (
        .x   (alu_x),
        .y   (alu_y),
        .sub (alu_sub),
        .sum (alu_sum)
    );

    kdc_pal #(
        .VALUE_WIDTH (W)
    ) u_pal (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (pal_start),
        .value   (pal_value),
        .stat    (pal_stat)
    );

    assign pal_start = (state_reg == ST_PALA) || (state_reg == ST_PALB);
    assign pal_value = (state_reg == ST_PALB) ? opnd1_reg : opnd0_reg;

    // Fit the value width to the fixed output field width
    assign entry_wide = {{OW{1'b0}}, entry_reg};
    assign res_wide   = {{OW{1'b0}}, res_reg};

    always_comb begin
        state_next   = state_reg;
        entry_next   = entry_reg;
        opnd0_next   = opnd0_reg;
        opnd1_next   = opnd1_reg;
        count_next   = count_reg;
        digit_next   = digit_reg;
        acc_next     = acc_reg;
        lo_next      = lo_reg;
        cnt_next     = cnt_reg;
        ev_next      = ev_reg;
        res_next     = res_reg;
        p1_next      = p1_reg;
        p2_next      = p2_reg;
        m_valid_next = m_valid_reg;
        m_ev_next    = m_ev_reg;
        m_entry_next = m_entry_reg;
        m_res_next   = m_res_reg;
        m_held_next  = m_held_reg;
        m_p1_next    = m_p1_reg;
        m_p2_next    = m_p2_reg;
        m_wl_next    = m_wl_reg;
        alu_x        = '0;
        alu_y        = '0;
        alu_sub      = 1'b0;

        // Drop the held result once the sink takes it
        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    ev_next    = kdc_pkg::EV_IGNORED;
                    res_next   = '0;
                    p1_next    = 1'b0;
                    p2_next    = 1'b0;
                    state_next = ST_FINISH;
                    unique case (s_tdata) inside
                        kdc_pkg::KEY_F: begin
                            if (count_reg == 2'd2) begin
                                ev_next = kdc_pkg::EV_FULL;
                            end else begin
                                if (count_reg[0]) begin
                                    opnd1_next = entry_reg;
                                end else begin
                                    opnd0_next = entry_reg;
                                end
                                count_next = count_reg + 2'd1;
                                entry_next = '0;
                                ev_next    = kdc_pkg::EV_STORED;
                            end
                        end
                        kdc_pkg::KEY_E: begin
                            entry_next = '0;
                            ev_next    = kdc_pkg::EV_CLEARED;
                        end
                        [kdc_pkg::KEY_0:kdc_pkg::KEY_9]: begin
                            digit_next = 4'(s_tdata - kdc_pkg::KEY_0);
                            state_next = ST_MUL10;
                        end
                        kdc_pkg::KEY_A, kdc_pkg::KEY_B, kdc_pkg::KEY_C, kdc_pkg::KEY_D: begin
                            // Operators act only on a full store
                            if (count_reg == 2'd2) begin
                                unique case (s_tdata)
                                    kdc_pkg::KEY_A: state_next = ST_ADD;
                                    kdc_pkg::KEY_B: state_next = ST_SUB;
                                    kdc_pkg::KEY_C: begin
                                        acc_next   = '0;
                                        lo_next    = opnd1_reg;
                                        cnt_next   = CW'(W);
                                        state_next = ST_MUL;
                                    end
                                    kdc_pkg::KEY_D: state_next = ST_PALA;
                                    default: ;
                                endcase
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MUL10: begin
                // Ten times the entry as eight times plus two times
                alu_x      = {1'b0, entry_reg, 3'b000};
                alu_y      = {3'b000, entry_reg, 1'b0};
                acc_next   = alu_sum;
                state_next = ST_ADDD;
            end
            ST_ADDD: begin
                alu_x = acc_reg;
                alu_y = {{(AW-4){1'b0}}, digit_reg};
                if (alu_sum[AW-1:W] != '0) begin
                    entry_next = '0;
                    ev_next    = kdc_pkg::EV_OVF_RESET;
                end else begin
                    entry_next = alu_sum[W-1:0];
                    ev_next    = kdc_pkg::EV_DIGIT;
                end
                state_next = ST_FINISH;
            end
            ST_ADD: begin
                alu_x = {4'b0000, opnd0_reg};
                alu_y = {4'b0000, opnd1_reg};
                if (alu_sum[W]) begin
                    ev_next = kdc_pkg::EV_OVERFLOW;
                end else begin
                    ev_next  = kdc_pkg::EV_RESULT;
                    res_next = alu_sum[W-1:0];
                end
                entry_next = '0;
                count_next = 2'd0;
                state_next = ST_FINISH;
            end
            ST_SUB: begin
                alu_x   = {4'b0000, opnd0_reg};
                alu_y   = {4'b0000, opnd1_reg};
                alu_sub = 1'b1;
                // A negative difference shows in the top bit
                if (alu_sum[AW-1]) begin
                    ev_next = kdc_pkg::EV_OVERFLOW;
                end else begin
                    ev_next  = kdc_pkg::EV_RESULT;
                    res_next = alu_sum[W-1:0];
                end
                entry_next = '0;
                count_next = 2'd0;
                state_next = ST_FINISH;
            end
            ST_MUL: begin
                // Shift-add: one multiplier bit per cycle, product forms in acc:lo
                alu_x    = {4'b0000, acc_reg[W-1:0]};
                alu_y    = lo_reg[0] ? {4'b0000, opnd0_reg} : '0;
                acc_next = {4'b0000, alu_sum[W:1]};
                lo_next  = {alu_sum[0], lo_reg[W-1:1]};
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    state_next = ST_MULEND;
                end
            end
            ST_MULEND: begin
                // Any bit in the upper half of the product is an overflow
                if (acc_reg[W-1:0] != '0) begin
                    ev_next = kdc_pkg::EV_OVERFLOW;
                end else begin
                    ev_next  = kdc_pkg::EV_RESULT;
                    res_next = lo_reg;
                end
                entry_next = '0;
                count_next = 2'd0;
                state_next = ST_FINISH;
            end
            ST_PALA: begin
                state_next = ST_PALA_W;
            end
            ST_PALA_W: begin
                if (pal_stat.done) begin
                    p1_next    = pal_stat.is_pal;
                    state_next = ST_PALB;
                end
            end
            ST_PALB: begin
                state_next = ST_PALB_W;
            end
            ST_PALB_W: begin
                if (pal_stat.done) begin
                    p2_next    = pal_stat.is_pal;
                    ev_next    = kdc_pkg::EV_PAL;
                    entry_next = '0;
                    count_next = 2'd0;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // Hold here until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_ev_next    = ev_reg;
                    m_entry_next = entry_wide[OW-1:0];
                    m_res_next   = res_wide[OW-1:0];
                    m_held_next  = count_reg;
                    m_p1_next    = p1_reg;
                    m_p2_next    = p2_reg;
                    m_wl_next    = p1_reg & p2_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            entry_reg   <= '0;
            count_reg   <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            entry_reg   <= entry_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        opnd0_reg   <= opnd0_next;
        opnd1_reg   <= opnd1_next;
        digit_reg   <= digit_next;
        acc_reg     <= acc_next;
        lo_reg      <= lo_next;
        cnt_reg     <= cnt_next;
        ev_reg      <= ev_next;
        res_reg     <= res_next;
        p1_reg      <= p1_next;
        p2_reg      <= p2_next;
        m_ev_reg    <= m_ev_next;
        m_entry_reg <= m_entry_next;
        m_res_reg   <= m_res_next;
        m_held_reg  <= m_held_next;
        m_p1_reg    <= m_p1_next;
        m_p2_reg    <= m_p2_next;
        m_wl_reg    <= m_wl_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_ev_reg;
    assign m_tdata  = {3'b000, m_wl_reg, m_p2_reg, m_p1_reg, m_held_reg, m_res_reg, m_entry_reg};

`ifndef SYNTHESIS
    // The operand store never counts past two
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("operand count out of range");

    // A taken key keeps the block busy in the following cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("key accepted back to back");

    // Palindrome flags appear only with the palindrome event
    a_flags_only_pal: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_ev_reg != kdc_pkg::EV_PAL)) |-> (!m_p1_reg && !m_p2_reg && !m_wl_reg))
        else $error("palindrome flags outside palindrome event");

    // A nonzero result goes only with the result event
    a_res_only_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_ev_reg != kdc_pkg::EV_RESULT)) |-> (m_res_reg == '0))
        else $error("result value outside result event");

    // Every operator that runs empties the store
    a_op_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_ev_reg == kdc_pkg::EV_RESULT || m_ev_reg == kdc_pkg::EV_OVERFLOW
            || m_ev_reg == kdc_pkg::EV_PAL)) |-> (m_held_reg == 2'd0))
        else $error("operand store not emptied after operator");
`endif

endmodule

/* rtl/kdc_alu.sv */
// Shared adder/subtractor used by the entry, add, subtract and multiply steps of the sequencer.
module kdc_alu #(
    parameter int WIDTH = 36
) (
    input  logic [WIDTH-1:0] x,
    input  logic [WIDTH-1:0] y,
    input  logic             sub,
    output logic [WIDTH-1:0] sum
);

    // Two's complement subtract: invert y and add one through the carry
    assign sum = x + (sub ? ~y : y) + {{(WIDTH-1){1'b0}}, sub};

endmodule

/* rtl/kdc_pal.sv */
// Iterative decimal palindrome test: binary to BCD conversion, then digit alignment.
module kdc_pal #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] value,
    output kdc_pkg::pal_stat_t     stat
);

    localparam int W  = VALUE_WIDTH;
    localparam int ND = (W * 30103) / 100000 + 1;  // decimal digits of the largest value
    localparam int BW = 4 * ND;
    localparam int CW = $clog2(W + 1);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_CONV  = 2'd1;
    localparam logic [1:0] PH_ALIGN = 2'd2;

    logic [1:0]    phase_reg, phase_next;
    logic [W-1:0]  bin_reg, bin_next;
    logic [BW-1:0] bcd_reg, bcd_next;
    logic [BW-1:0] mir_reg, mir_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic          match_reg, match_next;

    logic [BW-1:0] adj;
    logic [BW-1:0] shifted;
    logic [BW-1:0] mir_w;
    logic          top_zero;

    // Double dabble: add three to every digit of five or more, then shift one bit in
    always_comb begin
        logic [3:0] dig;
        for (int i = 0; i < ND; i++) begin
            dig = bcd_reg[4*i +: 4];
            adj[4*i +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
        end
        shifted = {adj[BW-2:0], bin_reg[W-1]};
        for (int i = 0; i < ND; i++) begin
            mir_w[4*i +: 4] = shifted[4*(ND-1-i) +: 4];
        end
    end

    assign top_zero = (bcd_reg[BW-1:BW-4] == 4'd0);

    always_comb begin
        phase_next = phase_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        mir_next   = mir_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        match_next = match_reg;
        unique case (phase_reg)
            PH_IDLE: begin
                if (start) begin
                    bin_next   = value;
                    bcd_next   = '0;
                    cnt_next   = CW'(W);
                    phase_next = PH_CONV;
                end
            end
            PH_CONV: begin
                bcd_next = shifted;
                bin_next = {bin_reg[W-2:0], 1'b0};
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    mir_next   = mir_w;
                    phase_next = PH_ALIGN;
                end
            end
            PH_ALIGN: begin
                // Left-align the digits; the aligned string equals its mirror
                // exactly when the number reads the same both ways
                if (!top_zero || bcd_reg == '0) begin
                    match_next = (bcd_reg == mir_reg);
                    done_next  = 1'b1;
                    phase_next = PH_IDLE;
                end else begin
                    bcd_next = {bcd_reg[BW-5:0], 4'b0000};
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
        bin_reg   <= bin_next;
        bcd_reg   <= bcd_next;
        mir_reg   <= mir_next;
        cnt_reg   <= cnt_next;
        match_reg <= match_next;
    end

    assign stat.done   = done_reg;
    assign stat.is_pal = match_reg;

endmodule
